@@ rtl/albr_pkg.sv @@
package albr_pkg;

  // Bin layout
  localparam int NUM_BINS    = 10;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);
  localparam int COUNT_W     = 16;
  localparam int BOUND_W     = COUNT_W + BIN_IDX_W;
  localparam int LEVEL_W     = 7;
  localparam int LEVEL_STEP  = 100 / NUM_BINS;

  // Levels
  localparam logic [LEVEL_W-1:0] FLOOR_LEVEL = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL   = LEVEL_W'(100);

  // Configuration registers and their reset values
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SETTLE_W   = 2;
  localparam logic [COUNT_W-1:0]  BIN_WIDTH_RST = COUNT_W'(2097);
  localparam logic [COUNT_W-1:0]  FLOOR_RST     = COUNT_W'(1834);
  localparam logic [SETTLE_W-1:0] SETTLE_RST    = SETTLE_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = CFG_IDX_W'(2);

  // Item kinds on the input side
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output beat width, padded to whole bytes
  localparam int RES_W = 1 + LEVEL_W + LEVEL_W + LEVEL_W + 1;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic               is_tick;
    logic               has_level;
    logic [LEVEL_W-1:0] level;
  } albr_cmd_t;

  // One result, last field in the lowest bits
  typedef struct packed {
    logic               ramp_active;
    logic [LEVEL_W-1:0] target_level;
    logic [LEVEL_W-1:0] committed_level;
    logic [LEVEL_W-1:0] drive_level;
    logic               drive_valid;
  } albr_res_t;

endpackage

@@ rtl/albr_front.sv @@
module albr_front
  import albr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_wr_t            cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [COUNT_W-1:0] light_count,
  output logic               q_push,
  output albr_cmd_t          q_cmd,
  input  logic               q_full
);

  logic [BOUND_W-1:0] bound [1:NUM_BINS-1];
  logic [COUNT_W-1:0] floor_count;
  logic [BOUND_W-1:0] twice;
  logic [NUM_BINS-1:0] above;
  logic               below_floor;

  // Hold bin bounds precomputed from the bin width, and the floor
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k < NUM_BINS; k++) begin
        bound[k] <= BOUND_W'(BIN_WIDTH_RST) * BOUND_W'(k);
      end
      floor_count <= FLOOR_RST;
    end else if (cfg.en) begin
      if (cfg.idx == REG_BIN_WIDTH) begin
        for (int k = 1; k < NUM_BINS; k++) begin
          bound[k] <= BOUND_W'(cfg.data) * BOUND_W'(k);
        end
      end
      if (cfg.idx == REG_FLOOR) begin
        floor_count <= cfg.data;
      end
    end
  end

  // Compare the doubled count against every bound at once
  always_comb begin
    twice       = BOUND_W'({light_count, 1'b0});
    below_floor = (light_count <= floor_count);
    above[0]    = |light_count;
    for (int k = 1; k < NUM_BINS; k++) begin
      above[k] = (twice > bound[k]);
    end
  end

  // Pick the level of the matching bin; the top range wins over the floor
  always_comb begin
    q_cmd.is_tick   = (operation == OP_TICK);
    q_cmd.has_level = 1'b0;
    q_cmd.level     = '0;
    if (operation == OP_SAMPLE) begin
      for (int i = 0; i < NUM_BINS - 1; i++) begin
        if (above[i] && !above[i+1]) begin
          q_cmd.has_level = 1'b1;
          q_cmd.level     = below_floor ? FLOOR_LEVEL : LEVEL_W'(LEVEL_STEP * (i + 1));
        end
      end
      if (above[NUM_BINS-1]) begin
        q_cmd.has_level = 1'b1;
        q_cmd.level     = MAX_LEVEL;
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

@@ rtl/albr_queue.sv @@
module albr_queue
  import albr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  albr_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output albr_cmd_t head
);

  albr_cmd_t          entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/albr_back.sv @@
module albr_back
  import albr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_wr_t   cfg,
  input  logic      q_not_empty,
  input  albr_cmd_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output albr_res_t out_res
);

  logic [SETTLE_W-1:0] settle_samples;

  logic [LEVEL_W-1:0]  committed, committed_next;
  logic [LEVEL_W-1:0]  target, target_next;
  logic [SETTLE_W-1:0] settle_count, settle_count_next;
  logic                settle_hold, settle_hold_next;
  logic signed [7:0]   ramp_delta, ramp_delta_next;
  logic [LEVEL_W-1:0]  ramp_step, ramp_step_next;
  logic                ramp_on, ramp_on_next;

  logic [LEVEL_W-1:0]  stopped;
  logic [LEVEL_W-1:0]  step_inc;
  logic [7:0]          mag;
  logic                drive_valid;
  logic [LEVEL_W-1:0]  drive_level;

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  // Committed level once a running ramp is stopped
  always_comb begin
    stopped = committed;
    if (ramp_on) begin
      if (ramp_delta > 0) begin
        stopped = committed - ramp_step;
      end else if (ramp_delta < 0) begin
        stopped = committed + ramp_step;
      end
    end
    step_inc = ramp_step + 1'b1;
    mag      = (ramp_delta < 0) ? 8'(-ramp_delta) : 8'(ramp_delta);
  end

  // Apply one item to the ramp state
  always_comb begin
    committed_next    = committed;
    target_next       = target;
    settle_count_next = settle_count;
    settle_hold_next  = settle_hold;
    ramp_delta_next   = ramp_delta;
    ramp_step_next    = ramp_step;
    ramp_on_next      = ramp_on;
    drive_valid       = 1'b0;
    drive_level       = '0;
    if (!q_head.is_tick) begin
      if (q_head.has_level) begin
        target_next = q_head.level;
      end
      if (committed != target_next) begin
        if (!settle_hold) begin
          if (settle_count < settle_samples) begin
            settle_count_next = settle_count + 1'b1;
          end else begin
            settle_hold_next = 1'b1;
            committed_next   = stopped;
            ramp_delta_next  = $signed({1'b0, stopped}) - $signed({1'b0, target_next});
            ramp_step_next   = '0;
            ramp_on_next     = 1'b1;
          end
        end
      end else begin
        settle_count_next = '0;
        settle_hold_next  = 1'b0;
      end
    end else if (ramp_on) begin
      if (ramp_delta == 0) begin
        ramp_on_next      = 1'b0;
        ramp_step_next    = '0;
        settle_count_next = '0;
        settle_hold_next  = 1'b0;
      end else begin
        ramp_step_next = step_inc;
        drive_valid    = 1'b1;
        drive_level    = (ramp_delta > 0) ? committed - step_inc : committed + step_inc;
        if ({1'b0, step_inc} == mag) begin
          committed_next    = drive_level;
          ramp_on_next      = 1'b0;
          ramp_step_next    = '0;
          settle_count_next = '0;
          settle_hold_next  = 1'b0;
        end
      end
    end
  end

  // Hold the settle register
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_samples <= SETTLE_RST;
    end else if (cfg.en && cfg.idx == REG_SETTLE) begin
      settle_samples <= cfg.data[SETTLE_W-1:0];
    end
  end

  // Advance state and load the output register on each popped item
  always_ff @(posedge clk) begin
    if (rst) begin
      committed    <= MAX_LEVEL;
      target       <= MAX_LEVEL;
      settle_count <= '0;
      settle_hold  <= 1'b0;
      ramp_delta   <= '0;
      ramp_step    <= '0;
      ramp_on      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        committed    <= committed_next;
        target       <= target_next;
        settle_count <= settle_count_next;
        settle_hold  <= settle_hold_next;
        ramp_delta   <= ramp_delta_next;
        ramp_step    <= ramp_step_next;
        ramp_on      <= ramp_on_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res.drive_valid     <= drive_valid;
      out_res.drive_level     <= drive_level;
      out_res.committed_level <= committed_next;
      out_res.target_level    <= target_next;
      out_res.ramp_active     <= ramp_on_next;
    end
  end

endmodule

@@ rtl/ambient_light_backlight_ramp_top.sv @@
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: light_count; tuser: operation
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: one result per item
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One item per cycle while m_axis_tready stays high; a result is presented once its beat
// is written into the queue entry and then loaded into the ramp unit output register.
// The bin compares run in parallel in the front; the ramp state updates once per item.
// rst is synchronous; it resets all registers but the queue entries and result payload.
// An output stall is absorbed by the two-entry queue; s_axis_tready drops when it fills.
module ambient_light_backlight_ramp_top
  import albr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [COUNT_W-1:0]    s_axis_tdata,   // [15:0] light_count
  input  logic [0:0]            s_axis_tuser,   // [0] operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] drive_valid, [7:1] drive_level, [14:8] committed_level,
  // [21:15] target_level, [22] ramp_active, [23] zero
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_wr_t   cfg;
  logic      q_push;
  albr_cmd_t q_cmd;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  albr_cmd_t q_head;
  albr_res_t res;

  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;

  albr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .operation   (s_axis_tuser[0]),
    .light_count (s_axis_tdata),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .q_full      (q_full)
  );

  albr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  albr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (res)
  );

  assign m_axis_tdata = OUT_W'(res);

  // A beat without a drive carries a zero drive level
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[7:1] == '0)
    else $error("drive level set without drive_valid");

  // Committed and target levels stay within percent range
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[14:8] <= MAX_LEVEL && m_axis_tdata[21:15] <= MAX_LEVEL)
    else $error("level out of range");

  // The input side only backs up after an output stall
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

endmodule

@@ tb/albr_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the ramp state and
// registers, and compares every result beat with the oldest prediction.
module albr_checker
  import albr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [COUNT_W-1:0]    s_axis_tdata,   // [15:0] light_count
  input  logic [0:0]            s_axis_tuser,   // [0] operation
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_W-1:0]      m_axis_tdata,   // [0] drive_valid .. [22] ramp_active
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  // Register copies
  logic [COUNT_W-1:0]  bin_width_half;
  logic [COUNT_W-1:0]  floor_count;
  logic [SETTLE_W-1:0] settle_samples;

  // Ramp state copy
  logic [LEVEL_W-1:0]  committed;
  logic [LEVEL_W-1:0]  target;
  logic [SETTLE_W-1:0] settle_cnt;
  logic signed [7:0]   ramp_delta;
  logic [LEVEL_W-1:0]  ramp_step;
  logic                ramp_on;
  logic                settle_hold;

  albr_res_t due_results_q[$];

  // Fold the steps taken so far into the committed level
  function automatic void end_ramp();
    if (ramp_on) begin
      if (ramp_delta > 0)
        committed = committed - ramp_step;
      else if (ramp_delta < 0)
        committed = committed + ramp_step;
      ramp_on   = 1'b0;
      ramp_step = '0;
    end
  endfunction

  function automatic void start_ramp();
    end_ramp();
    ramp_delta = $signed({1'b0, committed}) - $signed({1'b0, target});
    ramp_step  = '0;
    ramp_on    = 1'b1;
  endfunction

  // Map a light count to a target level, then run the settling counter
  function automatic void take_light(input logic [COUNT_W-1:0] count);
    int unsigned twice;
    int unsigned bw;
    twice = 32'(count) * 2;
    bw    = 32'(bin_width_half);
    for (int unsigned i = 0; i < NUM_BINS - 1; i++) begin
      if (twice > bw * i && twice <= bw * (i + 1))
        target = (count <= floor_count) ? FLOOR_LEVEL : LEVEL_W'(LEVEL_STEP * (i + 1));
    end
    if (twice > bw * (NUM_BINS - 1))
      target = MAX_LEVEL;

    if (committed != target) begin
      if (!settle_hold) begin
        if (settle_cnt < settle_samples) begin
          settle_cnt = settle_cnt + 1'b1;
        end else begin
          settle_hold = 1'b1;
          start_ramp();
        end
      end
    end else begin
      settle_cnt  = '0;
      settle_hold = 1'b0;
    end
  endfunction

  // Advance the state by one beat and return the result it should produce
  function automatic albr_res_t step_backlight(input logic op,
                                               input logic [COUNT_W-1:0] count);
    albr_res_t          res;
    logic [LEVEL_W-1:0] mag;
    res = '0;
    if (op == OP_SAMPLE) begin
      take_light(count);
    end else if (ramp_on) begin
      ramp_step = ramp_step + 1'b1;
      if (ramp_delta == 0) begin
        // nothing to move: stop without a drive
        end_ramp();
        settle_cnt  = '0;
        settle_hold = 1'b0;
      end else begin
        mag = (ramp_delta > 0) ? ramp_delta[LEVEL_W-1:0] : LEVEL_W'(-ramp_delta);
        res.drive_level = (ramp_delta > 0) ? committed - ramp_step : committed + ramp_step;
        res.drive_valid = 1'b1;
        if (ramp_step == mag) begin
          end_ramp();
          settle_cnt  = '0;
          settle_hold = 1'b0;
        end
      end
    end
    res.committed_level = committed;
    res.target_level    = target;
    res.ramp_active     = ramp_on;
    return res;
  endfunction

  always @(posedge clk) begin
    albr_res_t got;
    albr_res_t want;
    if (rst) begin
      bin_width_half = BIN_WIDTH_RST;
      floor_count    = FLOOR_RST;
      settle_samples = SETTLE_RST;
      committed      = MAX_LEVEL;
      target         = MAX_LEVEL;
      settle_cnt     = '0;
      ramp_delta     = '0;
      ramp_step      = '0;
      ramp_on        = 1'b0;
      settle_hold    = 1'b0;
      fail_count     = 0;
      due_results_q.delete();
    end else begin
      // Users must land register writes only while idle; not enforced by the block.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BIN_WIDTH: bin_width_half = cfg_data;
          REG_FLOOR:     floor_count    = cfg_data;
          REG_SETTLE:    settle_samples = cfg_data[SETTLE_W-1:0];
          default: ;
        endcase
      end

      // Compare a result beat with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = albr_res_t'(m_axis_tdata[RES_W-1:0]);
        if (due_results_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with nothing due: %h", $realtime, m_axis_tdata);
          fail_count++;
        end else begin
          want = due_results_q.pop_front();
          if (got.drive_valid !== want.drive_valid ||
              got.drive_level !== want.drive_level ||
              got.committed_level !== want.committed_level ||
              got.target_level !== want.target_level ||
              got.ramp_active !== want.ramp_active) begin
            if (fail_count < 10)
              $display({"%0t: mismatch valid/drive/committed/target/active ",
                        "exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d"}, $realtime,
                       want.drive_valid, want.drive_level, want.committed_level,
                       want.target_level, want.ramp_active,
                       got.drive_valid, got.drive_level, got.committed_level,
                       got.target_level, got.ramp_active);
            fail_count++;
          end
        end
      end

      // Predict the result of an accepted input beat
      if (s_axis_tvalid && s_axis_tready)
        due_results_q.push_back(step_backlight(s_axis_tuser[0], s_axis_tdata));
    end
    outstanding = due_results_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import albr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 140;
  localparam int NUM_PHASES     = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [COUNT_W-1:0]    s_axis_tdata = '0;   // [15:0] light_count
  logic [0:0]            s_axis_tuser = '0;   // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;        // [0] drive_valid .. [22] ramp_active
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  ambient_light_backlight_ramp_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  albr_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Give up after a long stretch with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat, after a random gap, and hold it until accepted
  task automatic send_item(input logic op, input logic [COUNT_W-1:0] count);
    int   gap;
    logic taken;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40)
      gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= count;
    s_axis_tuser  <= op;
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_ticks(input int n);
    for (int j = 0; j < n; j++)
      send_item(OP_TICK, COUNT_W'($urandom_range(65535)));
  endtask

  // Hold the input side until every predicted result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Counts aimed mostly at bin interiors and bin bounds for the current width
  function automatic logic [COUNT_W-1:0] pick_count(input int unsigned w);
    int unsigned r;
    int unsigned k;
    int unsigned c;
    r = $urandom_range(99);
    if (r < 10) begin
      c = $urandom_range(65535);
    end else if (r < 14) begin
      c = 0;
    end else if (r < 18) begin
      c = $urandom_range(1) ? 65535 : 1;
    end else begin
      k = $urandom_range(NUM_BINS - 1);
      if (r < 32)
        c = (k * w + $urandom_range(1)) / 2;   // on a bound or just past it
      else
        c = (k * w) / 2 + $urandom_range(w / 2);
    end
    if (c > 65535)
      c = 65535;
    return c[COUNT_W-1:0];
  endfunction

  initial begin
    int unsigned        w;
    int unsigned        fl;
    int unsigned        st;
    int                 sent;
    int                 run;
    int                 pause_at;
    logic [COUNT_W-1:0] cnt;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored tick, zero count, extremes, floor edge, bin edges
    send_item(OP_TICK, 16'hFFFF);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_SAMPLE, 16'd65535);
    send_item(OP_SAMPLE, 16'd1);
    send_item(OP_SAMPLE, 16'd1834);
    send_item(OP_SAMPLE, 16'd1835);      // third differing sample starts a ramp
    send_item(OP_SAMPLE, 16'd9436);      // ninth bound, ignored while holding
    send_item(OP_SAMPLE, 16'd9437);      // just above it: full level, clears the hold
    // Restart toward a new target, then walk part of the way
    repeat (3) send_item(OP_SAMPLE, 16'd5000);
    send_ticks(10);
    // Clear the hold, then restart where the drive stands: zero delta
    send_item(OP_SAMPLE, 16'd65535);
    repeat (3) send_item(OP_SAMPLE, 16'd9000);
    send_item(OP_TICK, 16'h0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          w  = 32'(BIN_WIDTH_RST);
          fl = 32'(FLOOR_RST);
          st = 32'(SETTLE_RST);
        end
        1: begin w = 1; fl = 0; st = 0; end
        2: begin w = 65535; fl = 65535; st = 3; end
        3: begin w = 0; fl = 500; st = 1; end   // zero width: any nonzero count is full level
        4, 5: begin
          w  = $urandom_range(200, 14000);
          fl = $urandom_range(9 * w / 2);
          st = $urandom_range(3);
        end
        6: begin w = $urandom_range(1, 65535); fl = $urandom_range(65535); st = $urandom_range(3); end
        default: begin w = 7000; fl = 0; st = 3; end
      endcase

      drain();
      write_reg(REG_BIN_WIDTH, w[CFG_DATA_W-1:0]);
      write_reg(REG_FLOOR, fl[CFG_DATA_W-1:0]);
      write_reg(REG_SETTLE, st[CFG_DATA_W-1:0]);
      cfg_valid <= 1'b0;

      // Idle pattern: none, sender only, receiver only, both
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 62; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 62; end
        default: begin tx_idle_pct = 37; rx_stall_pct <= 37; end
      endcase
      pause_at = (p == 1) ? PHASE_ITEMS / 2 : -1;

      // Runs of like samples to pass the settling count, and bursts of ticks
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 50) begin
          cnt = pick_count(w);
          run = $urandom_range(1, 5);
          for (int j = 0; j < run && sent < PHASE_ITEMS; j++) begin
            if ($urandom_range(9) == 0)
              cnt = pick_count(w);
            send_item(OP_SAMPLE, cnt);
            sent++;
            if (sent == pause_at)
              drain();
          end
        end else begin
          run = $urandom_range(1, 40);
          for (int j = 0; j < run && sent < PHASE_ITEMS; j++) begin
            send_item(OP_TICK, COUNT_W'($urandom_range(65535)));
            sent++;
            if (sent == pause_at)
              drain();
          end
        end
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
